// ===== sv/obbot_pkg.sv =====
// ----------------------------------------------------------------------------
// obbot_pkg
// Shared types, constants and the sine lookup for the oriented-box overlap test.
// ----------------------------------------------------------------------------
package obbot_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int TRIG_FRAC_BITS  = 14;
  localparam int TRIG_SHIFT      = 16 - TRIG_FRAC_BITS;

  // Field widths.
  localparam int CW = 24;  // center coordinate
  localparam int SW = 23;  // size
  localparam int AW = 9;   // angle
  localparam int TW = 16;  // trig value, signed

  // Datapath widths.
  localparam int MW  = CW + TW;        // center times axis component
  localparam int PW  = 2 * TW;         // trig times trig
  localparam int DW  = 2 * TRIG_FRAC_BITS + 2;  // magnitude of a trig dot product
  localparam int EW  = SW + DW;        // size times trig dot product
  localparam int PCW = MW + 1 + TRIG_FRAC_BITS + 1;  // scaled center projection
  localparam int LW  = 58;             // span bounds
  localparam int OW  = LW + 1;         // overlap

  localparam int IN_TDATA_W  = 208;
  localparam int OUT_TDATA_W = 72;

  localparam logic [31:0] OVERLAP_MAX = 32'h7FFF_FFFF;
  localparam int          RND_SHIFT   = 2 * TRIG_FRAC_BITS + 1;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [SW-1:0]        w;
    logic [SW-1:0]        h;
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
  } box_t;

  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
  } axis_t;

  // Load enables of the eight pipeline stages.
  typedef struct packed {
    logic ld_trig;
    logic ld_mul;
    logic ld_sum;
    logic ld_ext;
    logic ld_span;
    logic ld_ov;
    logic ld_pick;
    logic ld_out;
  } stage_ld_t;

  // Quarter-wave sine, 16 fraction bits.
  localparam logic [16:0] SIN_Q16 [91] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Sine of a reduced angle (0..359) with TRIG_FRAC_BITS fraction bits.
  function automatic logic signed [TW-1:0] sin_deg(input logic [AW-1:0] a);
    logic [6:0]  idx;
    logic        neg;
    logic [16:0] raw;
    logic [16:0] mag;
    if (a <= 9'd90) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      idx = 7'(9'd180 - a);
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      idx = 7'(a - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - a);
      neg = 1'b1;
    end
    raw = SIN_Q16[idx];
    mag = (raw + (17'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
    return neg ? -$signed(TW'(mag)) : $signed(TW'(mag));
  endfunction

  // Reduce an angle modulo 360 (input never exceeds 2 * 360).
  function automatic logic [AW-1:0] wrap_deg(input logic [AW:0] a);
    return (a >= 10'd360) ? AW'(a - 10'd360) : AW'(a);
  endfunction

endpackage

// ===== sv/obbot_trig.sv =====
// ----------------------------------------------------------------------------
// obbot_trig
// First stage: reduces a box angle and registers the box with its cosine/sine.
// ----------------------------------------------------------------------------
module obbot_trig (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic signed [obbot_pkg::CW-1:0] cx_i,
  input  logic signed [obbot_pkg::CW-1:0] cy_i,
  input  logic [obbot_pkg::SW-1:0]      w_i,
  input  logic [obbot_pkg::SW-1:0]      h_i,
  input  logic [obbot_pkg::AW-1:0]      angle_i,
  output obbot_pkg::box_t               box_o
);

  logic [obbot_pkg::AW-1:0] ang;
  logic [obbot_pkg::AW-1:0] ang_cos;
  obbot_pkg::box_t          box_d;
  obbot_pkg::box_t          box_q;

  // Angle reduction and table lookups.
  always_comb begin
    ang      = obbot_pkg::wrap_deg({1'b0, angle_i});
    ang_cos  = obbot_pkg::wrap_deg({1'b0, ang} + 10'd90);
    box_d.cx = cx_i;
    box_d.cy = cy_i;
    box_d.w  = w_i;
    box_d.h  = h_i;
    box_d.s  = obbot_pkg::sin_deg(ang);
    box_d.c  = obbot_pkg::sin_deg(ang_cos);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

// ===== sv/obbot_proj.sv =====
// ----------------------------------------------------------------------------
// obbot_proj
// Projects one box onto one axis over four stages and returns its span.
// The span is center projection +/- (w*|c.a| + h*|-s.ax + c.ay|).
// ----------------------------------------------------------------------------
module obbot_proj (
  input  logic                            clk_i,
  input  obbot_pkg::stage_ld_t            ld_i,
  input  obbot_pkg::box_t                 box_i,
  input  obbot_pkg::axis_t                axis_i,
  output logic signed [obbot_pkg::LW-1:0] lo_o,
  output logic signed [obbot_pkg::LW-1:0] hi_o
);

  localparam int MW  = obbot_pkg::MW;
  localparam int PW  = obbot_pkg::PW;
  localparam int DW  = obbot_pkg::DW;
  localparam int EW  = obbot_pkg::EW;
  localparam int PCW = obbot_pkg::PCW;
  localparam int LW  = obbot_pkg::LW;
  localparam int SW  = obbot_pkg::SW;

  // Stage 2: products.
  logic signed [MW-1:0] mx_q, my_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic [SW-1:0]        w2_q, h2_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_mul) begin
      mx_q <= box_i.cx * axis_i.x;
      my_q <= box_i.cy * axis_i.y;
      p1_q <= box_i.c * axis_i.x;
      p2_q <= box_i.s * axis_i.y;
      p3_q <= box_i.s * axis_i.x;
      p4_q <= box_i.c * axis_i.y;
      w2_q <= box_i.w;
      h2_q <= box_i.h;
    end
  end

  // Stage 3: center projection and trig dot products.
  logic signed [MW:0]   msum;
  logic signed [PW:0]   d1, d2;
  logic signed [PCW-1:0] pc_d, pc3_q;
  logic [DW-1:0]        ad1_d, ad2_d, ad1_q, ad2_q;
  logic [SW-1:0]        w3_q, h3_q;

  always_comb begin
    msum  = (MW+1)'(mx_q) + (MW+1)'(my_q);
    pc_d  = PCW'(msum) <<< (obbot_pkg::TRIG_FRAC_BITS + 1);
    d1    = (PW+1)'(p1_q) + (PW+1)'(p2_q);
    d2    = (PW+1)'(p4_q) - (PW+1)'(p3_q);
    ad1_d = DW'(d1[PW] ? -d1 : d1);
    ad2_d = DW'(d2[PW] ? -d2 : d2);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_sum) begin
      pc3_q <= pc_d;
      ad1_q <= ad1_d;
      ad2_q <= ad2_d;
      w3_q  <= w2_q;
      h3_q  <= h2_q;
    end
  end

  // Stage 4: half extents along the axis.
  logic [EW-1:0]         e1_d, e2_d, e1_q, e2_q;
  logic signed [PCW-1:0] pc4_q;

  assign e1_d = w3_q * ad1_q;
  assign e2_d = h3_q * ad2_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_ext) begin
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      pc4_q <= pc3_q;
    end
  end

  // Stage 5: span bounds.
  logic signed [EW+1:0] ext;
  logic signed [LW-1:0] lo_d, hi_d, lo_q, hi_q;

  always_comb begin
    ext  = $signed({1'b0, (EW+1)'(e1_q) + (EW+1)'(e2_q)});
    lo_d = LW'(pc4_q) - LW'(ext);
    hi_d = LW'(pc4_q) + LW'(ext);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_span) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

// ===== sv/obbot_select.sv =====
// ----------------------------------------------------------------------------
// obbot_select
// Forms the four overlaps, picks the smallest accepted one and rounds it.
// ----------------------------------------------------------------------------
module obbot_select (
  input  logic                            clk_i,
  input  obbot_pkg::stage_ld_t            ld_i,
  input  logic signed [obbot_pkg::LW-1:0] lo_a_i [4],
  input  logic signed [obbot_pkg::LW-1:0] hi_a_i [4],
  input  logic signed [obbot_pkg::LW-1:0] lo_b_i [4],
  input  logic signed [obbot_pkg::LW-1:0] hi_b_i [4],
  input  obbot_pkg::axis_t                axes_i [4],
  output logic                            collides_o,
  output logic signed [31:0]              min_overlap_o,
  output obbot_pkg::axis_t                axis_o
);

  localparam int OW = obbot_pkg::OW;

  // Stage 6: interval overlap on each axis.
  logic signed [OW-1:0] ov_d [4];
  logic signed [OW-1:0] ov_q [4];
  obbot_pkg::axis_t     ax6_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ov_d[i] = OW'((hi_a_i[i] < hi_b_i[i]) ? hi_a_i[i] : hi_b_i[i])
              - OW'((lo_a_i[i] > lo_b_i[i]) ? lo_a_i[i] : lo_b_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_ov) begin
      ov_q  <= ov_d;
      ax6_q <= axes_i;
    end
  end

  // Stage 7: axes before the first negative overlap are accepted; the
  // smallest of those wins, the earlier one on a tie.
  logic [3:0]           acc;
  logic                 sel01, sel23, sel_l;
  logic signed [OW-1:0] ov01, ov23, best_d, best_q;
  obbot_pkg::axis_t     ax01, ax23, ax_d, ax7_q;
  logic                 found_d, found_q, hit_q;

  always_comb begin
    acc[0]  = !ov_q[0][OW-1];
    acc[1]  = acc[0] && !ov_q[1][OW-1];
    acc[2]  = acc[1] && !ov_q[2][OW-1];
    acc[3]  = acc[2] && !ov_q[3][OW-1];
    sel01   = !acc[1] || (ov_q[0] <= ov_q[1]);
    sel23   = !acc[3] || (ov_q[2] <= ov_q[3]);
    ov01    = sel01 ? ov_q[0] : ov_q[1];
    ax01    = sel01 ? ax6_q[0] : ax6_q[1];
    ov23    = sel23 ? ov_q[2] : ov_q[3];
    ax23    = sel23 ? ax6_q[2] : ax6_q[3];
    sel_l   = !acc[2] || (ov01 <= ov23);
    best_d  = sel_l ? ov01 : ov23;
    ax_d    = sel_l ? ax01 : ax23;
    found_d = acc[0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_pick) begin
      best_q  <= best_d;
      ax7_q   <= ax_d;
      found_q <= found_d;
      hit_q   <= acc[3];
    end
  end

  // Stage 8: round half up to coordinate units and saturate.
  logic [OW:0]      rnd;
  logic [OW-obbot_pkg::RND_SHIFT:0] q;
  logic [31:0]      rep_d;
  obbot_pkg::axis_t ax_out_d;
  logic             coll_q;
  logic [31:0]      rep_q;
  obbot_pkg::axis_t ax_out_q;

  always_comb begin
    rnd = (OW+1)'(unsigned'(best_q)) + ((OW+1)'(1) << (obbot_pkg::RND_SHIFT - 1));
    q   = rnd[OW:obbot_pkg::RND_SHIFT];
    if (!found_q) begin
      rep_d = obbot_pkg::OVERLAP_MAX;
    end else if (q > ($bits(q))'(obbot_pkg::OVERLAP_MAX)) begin
      rep_d = obbot_pkg::OVERLAP_MAX;
    end else begin
      rep_d = 32'(q);
    end
    ax_out_d = found_q ? ax7_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_out) begin
      coll_q   <= hit_q;
      rep_q    <= rep_d;
      ax_out_q <= ax_out_d;
    end
  end

  assign collides_o    = coll_q;
  assign min_overlap_o = $signed(rep_q);
  assign axis_o        = ax_out_q;

endmodule

// ===== sv/obb_overlap_test.sv =====
// ----------------------------------------------------------------------------
// obb_overlap_test
// Separating-axis overlap test of two rotated rectangles.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         one box pair per request
//  m_axis    out        collision flag, smallest overlap, push axis
//
//  One request is taken every cycle unless the pipeline is full and stalled;
//  each result passes through the eight-stage multiply/add pipeline.
//  Reset clears every stage valid bit; data registers are not reset.
//  Each full stage holds while the stage after it is full and stalled, so empty
//  stages still fill while a result waits at the output.
// ----------------------------------------------------------------------------
module obb_overlap_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // a_center_x, a_center_y, a_width, a_height, a_angle,
  // b_center_x, b_center_y, b_width, b_height, b_angle, zero pad
  input  logic [obbot_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // collides, min_overlap, push_axis_x, push_axis_y, zero pad
  output logic [obbot_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  // Stage valid bits and ready chain.
  logic [8:1]           v_q;
  logic [9:1]           rdy;
  obbot_pkg::stage_ld_t ld;

  always_comb begin
    rdy[9] = m_axis_tready_i;
    for (int k = 8; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ld.ld_trig = rdy[1];
    ld.ld_mul  = rdy[2];
    ld.ld_sum  = rdy[3];
    ld.ld_ext  = rdy[4];
    ld.ld_span = rdy[5];
    ld.ld_ov   = rdy[6];
    ld.ld_pick = rdy[7];
    ld.ld_out  = rdy[8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= s_axis_tvalid_i;
      for (int k = 2; k <= 8; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = rdy[1];
  assign m_axis_tvalid_o = v_q[8];

  // Stage 1: angle lookup for both boxes.
  obbot_pkg::box_t box_a, box_b;

  obbot_trig u_trig_a (
    .clk_i   (clk_i),
    .ld_i    (ld.ld_trig),
    .cx_i    ($signed(s_axis_tdata_i[23:0])),
    .cy_i    ($signed(s_axis_tdata_i[47:24])),
    .w_i     (s_axis_tdata_i[70:48]),
    .h_i     (s_axis_tdata_i[93:71]),
    .angle_i (s_axis_tdata_i[102:94]),
    .box_o   (box_a)
  );

  obbot_trig u_trig_b (
    .clk_i   (clk_i),
    .ld_i    (ld.ld_trig),
    .cx_i    ($signed(s_axis_tdata_i[126:103])),
    .cy_i    ($signed(s_axis_tdata_i[150:127])),
    .w_i     (s_axis_tdata_i[173:151]),
    .h_i     (s_axis_tdata_i[196:174]),
    .angle_i (s_axis_tdata_i[205:197]),
    .box_o   (box_b)
  );

  // Test axes: A up, A minus-right, B up, B minus-right.
  obbot_pkg::axis_t axes [4];

  always_comb begin
    axes[0].x = -box_a.s;
    axes[0].y =  box_a.c;
    axes[1].x = -box_a.c;
    axes[1].y = -box_a.s;
    axes[2].x = -box_b.s;
    axes[2].y =  box_b.c;
    axes[3].x = -box_b.c;
    axes[3].y = -box_b.s;
  end

  // Axes travel beside the projection stages 2 to 5.
  obbot_pkg::axis_t ax2_q [4], ax3_q [4], ax4_q [4], ax5_q [4];

  always_ff @(posedge clk_i) begin
    if (ld.ld_mul)  ax2_q <= axes;
    if (ld.ld_sum)  ax3_q <= ax2_q;
    if (ld.ld_ext)  ax4_q <= ax3_q;
    if (ld.ld_span) ax5_q <= ax4_q;
  end

  // Stages 2 to 5: each box projected onto each axis.
  logic signed [obbot_pkg::LW-1:0] lo_a [4], hi_a [4], lo_b [4], hi_b [4];

  for (genvar i = 0; i < 4; i++) begin : g_axis
    obbot_proj u_proj_a (
      .clk_i  (clk_i),
      .ld_i   (ld),
      .box_i  (box_a),
      .axis_i (axes[i]),
      .lo_o   (lo_a[i]),
      .hi_o   (hi_a[i])
    );
    obbot_proj u_proj_b (
      .clk_i  (clk_i),
      .ld_i   (ld),
      .box_i  (box_b),
      .axis_i (axes[i]),
      .lo_o   (lo_b[i]),
      .hi_o   (hi_b[i])
    );
  end

  // Stages 6 to 8: overlaps, selection and rounding.
  logic               collides;
  logic signed [31:0] min_overlap;
  obbot_pkg::axis_t   push_axis;

  obbot_select u_select (
    .clk_i         (clk_i),
    .ld_i          (ld),
    .lo_a_i        (lo_a),
    .hi_a_i        (hi_a),
    .lo_b_i        (lo_b),
    .hi_b_i        (hi_b),
    .axes_i        (ax5_q),
    .collides_o    (collides),
    .min_overlap_o (min_overlap),
    .axis_o        (push_axis)
  );

  assign m_axis_tdata_o = {7'd0, push_axis.y, push_axis.x, min_overlap, collides};

endmodule

// ===== sv/obbot_checker.sv =====
// ----------------------------------------------------------------------------
// obbot_checker
// Port-level checks for the oriented-box overlap test.
// ----------------------------------------------------------------------------
module obbot_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [obbot_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [obbot_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // A stalled result stays valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // A collision never reports a negative overlap.
  a_coll_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> !m_axis_tdata_o[32])
    else $error("negative overlap on a collision");

  // A collision always carries a nonzero push axis.
  a_coll_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      (m_axis_tdata_o[48:33] != 16'd0 || m_axis_tdata_o[64:49] != 16'd0))
    else $error("collision without push axis");

  // The saturated overlap only appears with no accepted axis.
  a_none_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32:1] == obbot_pkg::OVERLAP_MAX |->
      (m_axis_tdata_o[48:33] == 16'd0 && m_axis_tdata_o[64:49] == 16'd0))
    else $error("push axis set without an accepted overlap");

endmodule

bind obb_overlap_test obbot_checker u_obbot_checker (.*);
